>>> rtl/acot_pkg.sv
// Shared types and constants for the AABB contact onset tracker.
// Used by the controller, the datapath and the top level; no dependencies.
package acot_pkg;

   // Default depth of the contact store
   localparam int MAX_CONTACTS = 16;

   localparam int CoordW = 24;
   localparam int SizeW  = 23;
   localparam int IdW    = 16;
   // Doubled-scale edge width: 2*centre +/- size fits in 26 bits signed
   localparam int EdgeW  = 26;

   typedef struct packed {
      logic signed [CoordW-1:0] self_center_x;
      logic signed [CoordW-1:0] self_center_y;
      logic        [SizeW-1:0]  self_size_x;
      logic        [SizeW-1:0]  self_size_y;
      logic signed [CoordW-1:0] other_center_x;
      logic signed [CoordW-1:0] other_center_y;
      logic        [SizeW-1:0]  other_size_x;
      logic        [SizeW-1:0]  other_size_y;
      logic        [IdW-1:0]    other_id;
   } req_word_type;

   typedef struct packed {
      logic entered;
      logic overlapping;
      logic store_full;
   } rsp_word_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } acot_cmd_type;

endpackage

>>> rtl/acot_ctrl.sv
// Controller of the contact onset tracker: two-state sequencer.
// Depends on acot_pkg for the command struct.
module acot_ctrl import acot_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output acot_cmd_type cmd,
   output logic         rsp_strobe
);

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_UPDATE = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   // Accept in idle, update the store in the following cycle
   always_comb begin
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      state_in    = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign strobe_in = cmd.commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == S_UPDATE);
   assign rsp_strobe = strobe_ff;

endmodule

>>> rtl/acot_datapath.sv
// Datapath of the contact onset tracker: overlap test, contact store, result word.
// Depends on acot_pkg for payload and command types.
module acot_datapath import acot_pkg::*; #(
   parameter int MaxContacts = MAX_CONTACTS
) (
   input  logic         clock,
   input  logic         reset,
   input  acot_cmd_type cmd,
   input  req_word_type req_word,
   output rsp_word_type rsp_word
);

   logic [IdW-1:0]         ids_ff [MaxContacts];
   logic [MaxContacts-1:0] valid_ff, valid_in;
   logic [MaxContacts-1:0] hit_ff, hit_in;
   logic                   ov_ff, ov_in;
   logic [IdW-1:0]         id_ff;
   rsp_word_type           rsp_ff, rsp_in;

   logic [MaxContacts-1:0] free_vec, free_oh, hit_oh;
   logic                   any_hit, any_free, do_record, do_remove;

   // Closed-interval test at doubled scale, exact without halving
   function automatic logic axis_overlap(
      input logic signed [CoordW-1:0] ca,
      input logic        [SizeW-1:0]  sa,
      input logic signed [CoordW-1:0] cb,
      input logic        [SizeW-1:0]  sb
   );
      logic signed [EdgeW-1:0] a2, b2, ha, hb;
      a2 = $signed({ca[CoordW-1], ca, 1'b0});
      b2 = $signed({cb[CoordW-1], cb, 1'b0});
      ha = $signed({3'b000, sa});
      hb = $signed({3'b000, sb});
      return ((a2 - ha) <= (b2 + hb)) && ((b2 - hb) <= (a2 + ha));
   endfunction

   // Overlap and id match on the incoming word
   assign ov_in = axis_overlap(req_word.self_center_x, req_word.self_size_x,
                               req_word.other_center_x, req_word.other_size_x) &&
                  axis_overlap(req_word.self_center_y, req_word.self_size_y,
                               req_word.other_center_y, req_word.other_size_y);

   always_comb begin
      for (int i = 0; i < MaxContacts; i++) begin
         hit_in[i] = valid_ff[i] && (ids_ff[i] == req_word.other_id);
      end
   end

   // Pick the lowest matching slot and the lowest free slot
   assign free_vec  = ~valid_ff;
   assign hit_oh    = hit_ff & (~hit_ff + {{(MaxContacts-1){1'b0}}, 1'b1});
   assign free_oh   = free_vec & (~free_vec + {{(MaxContacts-1){1'b0}}, 1'b1});
   assign any_hit   = |hit_ff;
   assign any_free  = |free_vec;
   assign do_record = cmd.commit && ov_ff && !any_hit && any_free;
   assign do_remove = cmd.commit && !ov_ff && any_hit;

   always_comb begin
      valid_in = valid_ff;
      if (do_record) begin
         valid_in = valid_ff | free_oh;
      end else if (do_remove) begin
         valid_in = valid_ff & ~hit_oh;
      end
   end

   always_comb begin
      rsp_in.entered     = ov_ff && !any_hit;
      rsp_in.overlapping = ov_ff;
      rsp_in.store_full  = ov_ff && !any_hit && !any_free;
   end

   // Hold the captured test results for the update cycle
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ov_ff  <= ov_in;
         hit_ff <= hit_in;
         id_ff  <= req_word.other_id;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Write the new id into its slot
   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxContacts; i++) begin
         if (do_record && free_oh[i]) begin
            ids_ff[i] <= id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

>>> rtl/aabb_contact_onset_tracker.sv
// AABB contact onset tracker: tests two boxes for overlap and tracks contact ids.
// A word accepted while idle is captured; the contact store is updated in UPDATE and
// the result is registered onto rsp_word with rsp_strobe. No new word is accepted
// during that match-then-update sequence (busy is high for one cycle).
// Reset (synchronous, active high) empties the contact store; results cannot stall.
// Depends on acot_pkg, acot_ctrl and acot_datapath.
module aabb_contact_onset_tracker import acot_pkg::*; #(
   parameter int MaxContacts = MAX_CONTACTS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   acot_cmd_type cmd;

   acot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   acot_datapath #(
      .MaxContacts (MaxContacts)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule
